>>> rtl/core/vrot_pkg.sv
// Shared types and constants for the vector rotation unit.
package vrot_pkg;

  localparam int unsigned VecW     = 16;
  localparam int unsigned FracBits = 14;
  localparam int unsigned CosShift = 2 * FracBits;
  localparam int unsigned SinShift = FracBits;
  localparam int unsigned OutShift = 42;
  localparam int unsigned SumW     = 64;
  localparam int unsigned RndW     = SumW - OutShift;

  // Product widths, exact for any 16-bit operands
  localparam int unsigned ProdW   = 2 * VecW;
  localparam int unsigned DotW    = ProdW + 2;
  localparam int unsigned CrossW  = ProdW + 1;
  localparam int unsigned OmcW    = VecW + 1;
  localparam int unsigned OmcDotW = OmcW + DotW;
  localparam int unsigned SinCrW  = VecW + CrossW;

  localparam logic signed [OmcW-1:0] QOne      = OmcW'(16384);
  localparam logic signed [SumW-1:0] RoundBias = SumW'(1) <<< (OutShift - 1);

  // Pipeline stage positions
  localparam int unsigned StgMul    = 0;
  localparam int unsigned StgComb   = 1;
  localparam int unsigned StgScale  = 2;
  localparam int unsigned StgAxis   = 3;
  localparam int unsigned StgAdd    = 4;
  localparam int unsigned StgOut    = 5;
  localparam int unsigned NumStages = 6;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegAxisI  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAxisJ  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAxisK  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSine   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCosine = 3'd4;

  typedef struct packed {
    logic signed [VecW-1:0] vec_i;
    logic signed [VecW-1:0] vec_j;
    logic signed [VecW-1:0] vec_k;
  } vrot_in_t;

  typedef struct packed {
    logic signed [VecW-1:0] rot_i;
    logic signed [VecW-1:0] rot_j;
    logic signed [VecW-1:0] rot_k;
    logic                   clipped;
  } vrot_out_t;

  typedef struct packed {
    logic signed [VecW-1:0] axis_i;
    logic signed [VecW-1:0] axis_j;
    logic signed [VecW-1:0] axis_k;
    logic signed [VecW-1:0] sine;
    logic signed [VecW-1:0] cosine;
  } vrot_cfg_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } vrot_ctl_t;

endpackage

>>> rtl/core/vector_rotate_about_axis_unit.sv
// Top level of the vector rotation unit: config registers, pipeline control.
//
//   channel  direction  handshake              beat contents
//   in       sink       in_valid_i/in_stall_o  vec_i, vec_j, vec_k
//   out      source     out_valid_o/out_stall_i rot_i, rot_j, rot_k, clipped
//   cfg      sink       cfg_valid_i/cfg_ready_o register index, 16-bit data
//
// One vector per cycle sustained while out_stall_i stays low; six register stages
// (products, dot/cross, scale, axis multiply 51 x 16 as the deepest, sum, round).
// Reset clears the stage valid bits and loads the config reset values.
// A stage holds its beat while the next is full and stalled; empty stages
// still load, so in_stall_o rises only once all six stages are full.
// cfg_ready_o is always high; config must only change while the pipe is empty.
module vector_rotate_about_axis_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  vrot_pkg::vrot_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output vrot_pkg::vrot_out_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vrot_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [vrot_pkg::VecW-1:0]           cfg_data_i
);

  vrot_pkg::vrot_cfg_t cfg_q;
  vrot_pkg::vrot_ctl_t ctl;

  logic [vrot_pkg::NumStages-1:0] valid_q, valid_d;
  logic [vrot_pkg::NumStages:0]   ready;

  // ---------------- configuration registers ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_i <= '0;
      cfg_q.axis_j <= '0;
      cfg_q.axis_k <= vrot_pkg::VecW'(vrot_pkg::QOne);
      cfg_q.sine   <= '0;
      cfg_q.cosine <= vrot_pkg::VecW'(vrot_pkg::QOne);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        vrot_pkg::RegAxisI:  cfg_q.axis_i <= cfg_data_i;
        vrot_pkg::RegAxisJ:  cfg_q.axis_j <= cfg_data_i;
        vrot_pkg::RegAxisK:  cfg_q.axis_k <= cfg_data_i;
        vrot_pkg::RegSine:   cfg_q.sine   <= cfg_data_i;
        vrot_pkg::RegCosine: cfg_q.cosine <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  // A stage may load when it is empty or its contents move on this cycle.
  assign ready[vrot_pkg::NumStages] = !out_stall_i;

  for (genvar s = 0; s < vrot_pkg::NumStages; s++) begin : g_ready
    assign ready[s] = !valid_q[s] || ready[s+1];
  end

  assign in_stall_o = !ready[0];
  assign ctl.load   = ready[vrot_pkg::NumStages-1:0];
  assign valid_d    = {valid_q[vrot_pkg::NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < vrot_pkg::NumStages; s++) begin
        if (ready[s]) begin
          valid_q[s] <= valid_d[s];
        end
      end
    end
  end

  assign out_valid_o = valid_q[vrot_pkg::NumStages-1];

  // ---------------- datapath ----------------
  vrot_datapath u_datapath (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // A stage whose successor could not take its beat still holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(valid_q & ~ready[vrot_pkg::NumStages:1]) & ~valid_q) == '0))
    else $error("stalled pipeline stage lost its beat");

  // Input is only held off when every stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with a bubble in the pipeline");

  // A clipped result carries at least one rail value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.clipped) |->
      (out_data_o.rot_i == 16'sh7fff || out_data_o.rot_i == 16'sh8000 ||
       out_data_o.rot_j == 16'sh7fff || out_data_o.rot_j == 16'sh8000 ||
       out_data_o.rot_k == 16'sh7fff || out_data_o.rot_k == 16'sh8000))
    else $error("clip flag set without a saturated component");
`endif

endmodule

>>> rtl/core/vrot_sat.sv
// Scaling of a pre-biased (round-half-up) sum and 16-bit saturation of one component.
module vrot_sat (
  input  logic signed [vrot_pkg::SumW-1:0] sum_i,
  output logic signed [vrot_pkg::VecW-1:0] rot_o,
  output logic                             clip_o
);

  logic signed [vrot_pkg::RndW-1:0] rnd;
  logic [vrot_pkg::RndW-vrot_pkg::VecW:0] top_bits;

  // Bias already added upstream; floor shift is a plain bit select
  assign rnd      = sum_i[vrot_pkg::SumW-1:vrot_pkg::OutShift];
  assign top_bits = rnd[vrot_pkg::RndW-1:vrot_pkg::VecW-1];
  assign clip_o   = !((&top_bits) || !(|top_bits));

  always_comb begin
    if (!clip_o) begin
      rot_o = rnd[vrot_pkg::VecW-1:0];
    end else if (rnd[vrot_pkg::RndW-1]) begin
      rot_o = {1'b1, {(vrot_pkg::VecW-1){1'b0}}};
    end else begin
      rot_o = {1'b0, {(vrot_pkg::VecW-1){1'b1}}};
    end
  end

endmodule

>>> rtl/core/vrot_datapath.sv
// Six-stage arithmetic pipeline for the Rodrigues rotation.
module vrot_datapath (
  input  logic                clk_i,
  input  vrot_pkg::vrot_ctl_t ctl_i,
  input  vrot_pkg::vrot_cfg_t cfg_i,
  input  vrot_pkg::vrot_in_t  in_data_i,
  output vrot_pkg::vrot_out_t out_data_o
);

  logic signed [vrot_pkg::VecW-1:0] axis [3];
  logic signed [vrot_pkg::VecW-1:0] vec  [3];
  logic signed [vrot_pkg::OmcW-1:0] omc;

  // stage 1: raw products
  logic signed [vrot_pkg::ProdW-1:0] s1_dot_d [3], s1_dot_q [3];
  logic signed [vrot_pkg::ProdW-1:0] s1_xa_d [3], s1_xa_q [3];
  logic signed [vrot_pkg::ProdW-1:0] s1_xb_d [3], s1_xb_q [3];
  logic signed [vrot_pkg::ProdW-1:0] s1_cv_d [3], s1_cv_q [3];
  // stage 2: dot and cross
  logic signed [vrot_pkg::DotW-1:0]   s2_dot_d, s2_dot_q;
  logic signed [vrot_pkg::CrossW-1:0] s2_cr_d [3], s2_cr_q [3];
  logic signed [vrot_pkg::ProdW-1:0]  s2_cv_q [3];
  // stage 3: (1-cos)*dot and sin*cross
  logic signed [vrot_pkg::OmcDotW-1:0] s3_od_d, s3_od_q;
  logic signed [vrot_pkg::SinCrW-1:0]  s3_sc_d [3], s3_sc_q [3];
  logic signed [vrot_pkg::ProdW-1:0]   s3_cv_q [3];
  // stage 4: axial term
  logic signed [vrot_pkg::SumW-1:0]   s4_ax_d [3], s4_ax_q [3];
  logic signed [vrot_pkg::SinCrW-1:0] s4_sc_q [3];
  logic signed [vrot_pkg::ProdW-1:0]  s4_cv_q [3];
  // stage 5: biased sums
  logic signed [vrot_pkg::SumW-1:0] s5_sum_d [3], s5_sum_q [3];
  // stage 6: output
  logic signed [vrot_pkg::VecW-1:0] rot [3];
  logic [2:0]                       clip;
  vrot_pkg::vrot_out_t              out_d, out_q;

  assign axis[0] = cfg_i.axis_i;
  assign axis[1] = cfg_i.axis_j;
  assign axis[2] = cfg_i.axis_k;
  assign vec[0]  = in_data_i.vec_i;
  assign vec[1]  = in_data_i.vec_j;
  assign vec[2]  = in_data_i.vec_k;
  assign omc     = vrot_pkg::QOne - vrot_pkg::OmcW'(cfg_i.cosine);

  // cross lane n: v[n+1]*a[n+2] - v[n+2]*a[n+1]
  always_comb begin
    s1_dot_d[0] = vrot_pkg::ProdW'(vec[0]) * vrot_pkg::ProdW'(axis[0]);
    s1_dot_d[1] = vrot_pkg::ProdW'(vec[1]) * vrot_pkg::ProdW'(axis[1]);
    s1_dot_d[2] = vrot_pkg::ProdW'(vec[2]) * vrot_pkg::ProdW'(axis[2]);
    s1_xa_d[0]  = vrot_pkg::ProdW'(vec[1]) * vrot_pkg::ProdW'(axis[2]);
    s1_xb_d[0]  = vrot_pkg::ProdW'(vec[2]) * vrot_pkg::ProdW'(axis[1]);
    s1_xa_d[1]  = vrot_pkg::ProdW'(vec[2]) * vrot_pkg::ProdW'(axis[0]);
    s1_xb_d[1]  = vrot_pkg::ProdW'(vec[0]) * vrot_pkg::ProdW'(axis[2]);
    s1_xa_d[2]  = vrot_pkg::ProdW'(vec[0]) * vrot_pkg::ProdW'(axis[1]);
    s1_xb_d[2]  = vrot_pkg::ProdW'(vec[1]) * vrot_pkg::ProdW'(axis[0]);
    for (int n = 0; n < 3; n++) begin
      s1_cv_d[n] = vrot_pkg::ProdW'(cfg_i.cosine) * vrot_pkg::ProdW'(vec[n]);
    end
  end

  always_comb begin
    s2_dot_d = vrot_pkg::DotW'(s1_dot_q[0]) + vrot_pkg::DotW'(s1_dot_q[1])
             + vrot_pkg::DotW'(s1_dot_q[2]);
    for (int n = 0; n < 3; n++) begin
      s2_cr_d[n] = vrot_pkg::CrossW'(s1_xa_q[n]) - vrot_pkg::CrossW'(s1_xb_q[n]);
    end
  end

  always_comb begin
    s3_od_d = vrot_pkg::OmcDotW'(omc) * vrot_pkg::OmcDotW'(s2_dot_q);
    for (int n = 0; n < 3; n++) begin
      s3_sc_d[n] = vrot_pkg::SinCrW'(cfg_i.sine) * vrot_pkg::SinCrW'(s2_cr_q[n]);
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      s4_ax_d[n] = vrot_pkg::SumW'(s3_od_q) * vrot_pkg::SumW'(axis[n]);
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      s5_sum_d[n] = (vrot_pkg::SumW'(s4_cv_q[n]) <<< vrot_pkg::CosShift)
                  + s4_ax_q[n]
                  - (vrot_pkg::SumW'(s4_sc_q[n]) <<< vrot_pkg::SinShift)
                  + vrot_pkg::RoundBias;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_sat
    vrot_sat u_sat (
      .sum_i  (s5_sum_q[g]),
      .rot_o  (rot[g]),
      .clip_o (clip[g])
    );
  end

  always_comb begin
    out_d.rot_i   = rot[0];
    out_d.rot_j   = rot[1];
    out_d.rot_k   = rot[2];
    out_d.clipped = |clip;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[vrot_pkg::StgMul]) begin
      s1_dot_q <= s1_dot_d;
      s1_xa_q  <= s1_xa_d;
      s1_xb_q  <= s1_xb_d;
      s1_cv_q  <= s1_cv_d;
    end
    if (ctl_i.load[vrot_pkg::StgComb]) begin
      s2_dot_q <= s2_dot_d;
      s2_cr_q  <= s2_cr_d;
      s2_cv_q  <= s1_cv_q;
    end
    if (ctl_i.load[vrot_pkg::StgScale]) begin
      s3_od_q <= s3_od_d;
      s3_sc_q <= s3_sc_d;
      s3_cv_q <= s2_cv_q;
    end
    if (ctl_i.load[vrot_pkg::StgAxis]) begin
      s4_ax_q <= s4_ax_d;
      s4_sc_q <= s3_sc_q;
      s4_cv_q <= s3_cv_q;
    end
    if (ctl_i.load[vrot_pkg::StgAdd]) begin
      s5_sum_q <= s5_sum_d;
    end
    if (ctl_i.load[vrot_pkg::StgOut]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> verif/tb_vector_rotate_about_axis_unit.sv
// Self-checking testbench for the vector rotation unit: random stalls, config sweeps, backpressure.
module tb_vector_rotate_about_axis_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import vrot_pkg::*;

  // Run shape
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned PhaseBeats  = 175;
  localparam int unsigned IdlePct     = 17;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned SteadyPhase = 3;
  localparam int unsigned HoldPhase   = 6;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  vrot_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  vrot_out_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [VecW-1:0]    cfg_data_i = '0;

  vector_rotate_about_axis_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the config registers as the block should hold them.
  // Reset values: axis along +z, zero angle (identity rotation).
  vrot_cfg_t cfg_now = '{axis_i: '0, axis_j: '0, axis_k: 16'sd16384,
                         sine: '0, cosine: 16'sd16384};

  vrot_in_t  vec_backlog[$];  // vectors waiting to be offered
  vrot_out_t rotated_q[$];    // rotations owed by the block, oldest first

  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  bit          steady = 1'b0;    // no idling on either side while set
  bit          hold_arm = 1'b0;  // one-cycle request for a long output hold-off
  int unsigned hold_left = 0;

  task automatic log_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // Scale a 2^42 sum back to an integer, round half up, clamp to 16 bits.
  // Bit 16 of the return carries the saturation flag.
  function automatic logic [VecW:0] round_sat(input longint sum);
    longint q;
    q = (sum + (longint'(1) <<< (OutShift - 1))) >>> OutShift;
    if (q > 32767) begin
      return {1'b1, 16'h7fff};
    end else if (q < -32768) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, q[VecW-1:0]};
  endfunction

  // Rodrigues: cos*v + (1-cos)(v.n)n - sin(v x n), every term exact at 2^42
  function automatic vrot_out_t rotate_vec(input vrot_in_t v);
    longint vi, vj, vk, ni, nj, nk, sn, cs;
    longint dot, cx, cy, cz, omc_dot, sum_i, sum_j, sum_k;
    logic [VecW:0] ri, rj, rk;
    vrot_out_t r;
    vi = longint'($signed(v.vec_i));
    vj = longint'($signed(v.vec_j));
    vk = longint'($signed(v.vec_k));
    ni = longint'($signed(cfg_now.axis_i));
    nj = longint'($signed(cfg_now.axis_j));
    nk = longint'($signed(cfg_now.axis_k));
    sn = longint'($signed(cfg_now.sine));
    cs = longint'($signed(cfg_now.cosine));
    dot = vi * ni + vj * nj + vk * nk;
    cx  = vj * nk - vk * nj;
    cy  = vk * ni - vi * nk;
    cz  = vi * nj - vj * ni;
    omc_dot = (longint'(QOne) - cs) * dot;
    sum_i = ((cs * vi) <<< CosShift) + omc_dot * ni - ((sn * cx) <<< SinShift);
    sum_j = ((cs * vj) <<< CosShift) + omc_dot * nj - ((sn * cy) <<< SinShift);
    sum_k = ((cs * vk) <<< CosShift) + omc_dot * nk - ((sn * cz) <<< SinShift);
    ri = round_sat(sum_i);
    rj = round_sat(sum_j);
    rk = round_sat(sum_k);
    r.rot_i   = ri[VecW-1:0];
    r.rot_j   = rj[VecW-1:0];
    r.rot_k   = rk[VecW-1:0];
    r.clipped = ri[VecW] | rj[VecW] | rk[VecW];
    return r;
  endfunction

  // Input side: offer the backlog, hold a stalled beat steady, predict on
  // every accepted beat. Config only changes while nothing is in flight, so
  // predicting at acceptance sees the right shadow.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rotated_q.push_back(rotate_vec(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (vec_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= vec_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, counted here so the sender keeps going meanwhile
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_beat(input vrot_out_t got);
    vrot_out_t want;
    beats_seen++;
    if (rotated_q.size() == 0) begin
      log_mismatch($sformatf("beat %0d arrived with nothing owed", beats_seen));
      return;
    end
    want = rotated_q.pop_front();
    if (got.rot_i !== want.rot_i) begin
      log_mismatch($sformatf("beat %0d rot_i got %0d want %0d", beats_seen,
                             $signed(got.rot_i), $signed(want.rot_i)));
    end
    if (got.rot_j !== want.rot_j) begin
      log_mismatch($sformatf("beat %0d rot_j got %0d want %0d", beats_seen,
                             $signed(got.rot_j), $signed(want.rot_j)));
    end
    if (got.rot_k !== want.rot_k) begin
      log_mismatch($sformatf("beat %0d rot_k got %0d want %0d", beats_seen,
                             $signed(got.rot_k), $signed(want.rot_k)));
    end
    if (got.clipped !== want.clipped) begin
      log_mismatch($sformatf("beat %0d clipped got %b want %b", beats_seen,
                             got.clipped, want.clipped));
    end
  endtask

  // Output side: check accepted beats, stall at random or during a hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_beat(out_data_o);
      end
      out_stall_i <= (hold_left != 0) || (!steady && $urandom_range(0, 99) < IdlePct);
    end
  end

  // One register write; starts on a fresh edge so back-to-back calls never
  // lower and raise valid in the same step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [VecW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegAxisI:  cfg_now.axis_i = val;
      RegAxisJ:  cfg_now.axis_j = val;
      RegAxisK:  cfg_now.axis_k = val;
      RegSine:   cfg_now.sine   = val;
      RegCosine: cfg_now.cosine = val;
      default: ;  // unmapped index, ignored by the block
    endcase
  endtask

  task automatic write_cfg(input vrot_cfg_t c);
    write_reg(RegAxisI, c.axis_i);
    write_reg(RegAxisJ, c.axis_j);
    write_reg(RegAxisK, c.axis_k);
    write_reg(RegSine, c.sine);
    write_reg(RegCosine, c.cosine);
  endtask

  // Checked on the falling edge, where every update of the rising one has settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (vec_backlog.size() != 0 || in_valid_i || rotated_q.size() != 0);
  endtask

  task automatic push_vec(input int vi, input int vj, input int vk);
    vrot_in_t v;
    v.vec_i = VecW'(vi);
    v.vec_j = VecW'(vj);
    v.vec_k = VecW'(vk);
    vec_backlog.push_back(v);
  endtask

  // Extremes, signs and small values: both saturation directions and rounding
  task automatic push_directed();
    push_vec(0, 0, 0);
    push_vec(32767, 32767, 32767);
    push_vec(-32768, -32768, -32768);
    push_vec(1, -1, 0);
    push_vec(32767, -32768, 1);
    push_vec(100, -200, 300);
    push_vec(-1, -1, -1);
  endtask

  function automatic logic [VecW-1:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
      4: return VecW'($signed($urandom_range(0, 511)) - 256);
      default: return VecW'($urandom);
    endcase
  endfunction

  function automatic logic [VecW-1:0] corner_q14();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'hc000;
      2: return '0;
      3: return 16'h4000;
      default: return 16'h7fff;
    endcase
  endfunction

  function automatic logic [VecW-1:0] to_q14(input real x);
    return VecW'($rtoi($floor(16384.0 * x + 0.5)));
  endfunction

  // Three kinds of setting: a real rotation (unit axis, angle on the unit
  // circle), corner values, and arbitrary 16-bit words.
  function automatic vrot_cfg_t random_cfg(input int unsigned kind);
    vrot_cfg_t c;
    real th, ph, ang;
    case (kind)
      0: begin
        th  = $urandom_range(0, 62831) / 10000.0;
        ph  = $urandom_range(0, 31415) / 10000.0;
        ang = $urandom_range(0, 62831) / 10000.0;
        c.axis_i = to_q14($sin(ph) * $cos(th));
        c.axis_j = to_q14($sin(ph) * $sin(th));
        c.axis_k = to_q14($cos(ph));
        c.sine   = to_q14($sin(ang));
        c.cosine = to_q14($cos(ang));
      end
      1: begin
        c.axis_i = corner_q14();
        c.axis_j = corner_q14();
        c.axis_k = corner_q14();
        c.sine   = corner_q14();
        c.cosine = corner_q14();
      end
      default: begin
        c = vrot_cfg_t'({$urandom, $urandom, $urandom});
      end
    endcase
    return c;
  endfunction

  initial begin
    vrot_cfg_t c;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity rotation straight from reset
    push_directed();
    wait_drained();

    // Quarter turn about z
    c = '{axis_i: '0, axis_j: '0, axis_k: 16'sd16384, sine: 16'sd16384, cosine: '0};
    write_cfg(c);
    push_directed();
    wait_drained();

    // Registers far off the unit circle, then writes to unmapped indexes
    // that must leave them untouched
    c = '{axis_i: 16'sh7fff, axis_j: 16'sh8000, axis_k: 16'sh8000,
          sine: 16'sh8000, cosine: 16'sh7fff};
    write_cfg(c);
    write_reg(RegCosine + 3'd1, 16'h1234);
    write_reg(RegCosine + 3'd2, 16'hffff);
    write_reg(RegCosine + 3'd3, 16'h0000);
    push_directed();
    wait_drained();

    for (int unsigned p = 0; p < RandPhases; p++) begin
      write_cfg(random_cfg(p % 3));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(RegCosine + CfgIdxW'($urandom_range(1, 3)), VecW'($urandom));
      end
      @(negedge clk_i);
      steady = (p == SteadyPhase);
      repeat (PhaseBeats) begin
        push_vec(pick_comp(), pick_comp(), pick_comp());
      end
      if (p == HoldPhase) begin
        // Output held back long enough for the pipe to fill and stall its input
        hold_arm = 1'b1;
        @(negedge clk_i);
        hold_arm = 1'b0;
      end
      wait_drained();
      steady = 1'b0;
    end

    // Room for any stray beat to show up
    repeat (NumStages + 4) @(negedge clk_i);
    if (rotated_q.size() != 0) begin
      log_mismatch($sformatf("%0d rotations never arrived", rotated_q.size()));
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
